FILE: src/srds_pkg.sv
package srds_pkg;

  // Field and bus widths.
  localparam int RATE_W        = 64;
  localparam int FRAC_W        = 52;
  localparam int MANT_W        = 53;
  localparam int EXPF_W        = 11;
  localparam int EXP_SH_W      = 5;
  localparam int SYNTH_W       = 33;
  localparam int DIV_OUT_W     = 5;
  localparam int FILT_W        = 25;
  localparam int FHZ_W         = 32;
  localparam int THR_W         = 34;
  localparam int IN_TDATA_W    = 64;
  localparam int OUT_TDATA_W   = 64;

  // IEEE-754 double exponent bias and the largest accepted biased exponent field.
  localparam logic [EXPF_W-1:0] EXP_BIAS    = 11'd1023;
  localparam logic [EXPF_W-1:0] EXP_TOP     = 11'd1054;
  localparam logic [FRAC_W-1:0] FRAC_ONES   = '1;

  // Default number of tries of the divider search.
  localparam int MAX_TRIES_DEF = 32;

  // Baseband filter widths in Hz, ascending.
  localparam int FILTER_COUNT  = 16;
  localparam int FILT_IDX_W    = 4;
  localparam logic [FILT_W-1:0] FILTER_TABLE [FILTER_COUNT] = '{
    25'd1750000,  25'd2500000,  25'd3500000,  25'd5000000,
    25'd5500000,  25'd6000000,  25'd7000000,  25'd8000000,
    25'd9000000,  25'd10000000, 25'd12000000, 25'd14000000,
    25'd15000000, 25'd20000000, 25'd24000000, 25'd28000000
  };

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_ROUND,
    ST_TRIPLE,
    ST_FILTER,
    ST_FINISH
  } srds_state_t;

  // Commands from the controller to the datapath.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_STEP,
    CMD_FALLBACK,
    CMD_ROUND,
    CMD_TRIPLE,
    CMD_FILT,
    CMD_FINISH
  } srds_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_err;
    logic hit;
    logic last;
    logic filt_last;
    logic out_free;
  } srds_status_t;

endpackage

FILE: src/srds_datapath.sv
module srds_datapath #(
  parameter int MAX_TRIES = srds_pkg::MAX_TRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [srds_pkg::RATE_W-1:0]      rate_bits,
  input  srds_pkg::srds_cmd_t              cmd,
  input  logic                             out_tready,
  output srds_pkg::srds_status_t           status,
  output logic                             out_tvalid,
  output logic [srds_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tuser
);
  import srds_pkg::*;

  localparam int DIV_W  = $clog2(MAX_TRIES);
  localparam int PROD_W = MANT_W + DIV_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int MUL_W  = FILT_W + DIV_W + 2;

  // Fields of the incoming double.
  logic                  sign_w;
  logic [EXPF_W-1:0]     expf_w;
  logic [FRAC_W-1:0]     fbits_w;
  logic [EXP_SH_W-1:0]   e_in_w;
  logic [FRAC_W-1:0]     frac_in_w;
  logic [FRAC_W-1:0]     mask_in_w;
  logic [MANT_W-1:0]     mant_in_w;
  logic                  in_err_w;

  // Working registers.
  logic                  err_r;
  logic [EXP_SH_W-1:0]   e_r;
  logic [FRAC_W-1:0]     frac_r;
  logic [FRAC_W-1:0]     mask_r;
  logic [MANT_W-1:0]     mant_r;
  logic [FRAC_W-1:0]     acc_r;
  logic [PROD_W-1:0]     pacc_r;
  logic [DIV_W-1:0]      div_r;
  logic [FHZ_W-1:0]      fhz_r;
  logic [THR_W-1:0]      thr_r;
  logic [FILT_IDX_W-1:0] k_r;
  logic [FILT_W-1:0]     best_r;

  // Output register.
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_tuser_r;

  // Combinational results of each step.
  logic                  hit_w;
  logic [5:0]            s_w;
  logic [SUM_W-1:0]      half_w;
  logic [SUM_W-1:0]      sum_w;
  logic [SUM_W-1:0]      shr_w;
  logic [FHZ_W-1:0]      fhz_w;
  logic [THR_W-1:0]      thr_w;
  logic [MUL_W-1:0]      mul_w;
  logic                  fit_w;
  logic                  out_free_w;

  // Decode the input beat; the fraction is left aligned in 52 bits.
  assign sign_w    = rate_bits[RATE_W-1];
  assign expf_w    = rate_bits[RATE_W-2:FRAC_W];
  assign fbits_w   = rate_bits[FRAC_W-1:0];
  assign in_err_w  = sign_w || (expf_w < EXP_BIAS) || (expf_w > EXP_TOP);
  assign e_in_w    = EXP_SH_W'(expf_w - EXP_BIAS);
  assign frac_in_w = fbits_w << e_in_w;
  assign mask_in_w = FRAC_ONES << ({1'b0, e_in_w} + 6'd4);
  assign mant_in_w = {1'b1, fbits_w};

  // The current multiple qualifies when its masked bits are all zero or all one.
  assign hit_w = ((acc_r & mask_r) == '0) || ((~acc_r & mask_r) == '0);

  // Round rate times divider to an integer and saturate to 32 bits.
  assign s_w    = 6'd52 - {1'b0, e_r};
  assign half_w = SUM_W'(1) << (s_w - 6'd1);
  assign sum_w  = {1'b0, pacc_r} + half_w;
  assign shr_w  = sum_w >> s_w;
  assign fhz_w  = (shr_w[SUM_W-1:FHZ_W] != '0) ? '1 : shr_w[FHZ_W-1:0];

  // Three times the rounded frequency.
  assign thr_w = {1'b0, fhz_r, 1'b0} + {2'b00, fhz_r};

  // An entry fits when entry * 4 * divider does not exceed 3 * frequency.
  assign mul_w = (MUL_W'(FILTER_TABLE[k_r]) * MUL_W'(div_r)) << 2;
  assign fit_w = THR_W'(mul_w) <= thr_r;

  assign out_free_w = !out_valid_r || out_tready;

  // Status to the controller.
  always_comb begin
    status.in_err    = in_err_w;
    status.hit       = hit_w;
    status.last      = (div_r == DIV_W'(MAX_TRIES - 1));
    status.filt_last = (k_r == FILT_IDX_W'(FILTER_COUNT - 1));
    status.out_free  = out_free_w;
  end

  // Working registers, driven by the controller's command.
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        err_r  <= in_err_w;
        e_r    <= e_in_w;
        frac_r <= frac_in_w;
        mask_r <= mask_in_w;
        mant_r <= mant_in_w;
        acc_r  <= frac_in_w;
        pacc_r <= PROD_W'(mant_in_w);
        div_r  <= DIV_W'(1);
      end
      CMD_STEP: begin
        acc_r  <= acc_r + frac_r;
        pacc_r <= pacc_r + PROD_W'(mant_r);
        div_r  <= div_r + DIV_W'(1);
      end
      CMD_FALLBACK: begin
        pacc_r <= PROD_W'(mant_r);
        div_r  <= DIV_W'(1);
      end
      CMD_ROUND: begin
        fhz_r <= fhz_w;
      end
      CMD_TRIPLE: begin
        thr_r  <= thr_w;
        k_r    <= '0;
        best_r <= FILTER_TABLE[0];
      end
      CMD_FILT: begin
        if (fit_w) begin
          best_r <= FILTER_TABLE[k_r];
        end
        k_r <= k_r + FILT_IDX_W'(1);
      end
      CMD_FINISH: begin
        if (err_r) begin
          out_tdata_r <= {1'b0, FILTER_TABLE[0], DIV_OUT_W'(1), SYNTH_W'(0)};
        end else begin
          out_tdata_r <= {1'b0, best_r, DIV_OUT_W'(div_r), fhz_r, 1'b0};
        end
        out_tuser_r <= err_r;
      end
      default: begin
      end
    endcase
  end

  // Output valid: set when a result is loaded, cleared when it is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd == CMD_FINISH) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // A result is only loaded when the output register is free.
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_FINISH |-> out_free_w)
    else $error("result loaded over a pending beat");

  // An out-of-range beat carries zero frequency and a divider of one.
  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tuser_r) |->
      (out_tdata_r[SYNTH_W-1:0] == '0) &&
      (out_tdata_r[SYNTH_W+DIV_OUT_W-1:SYNTH_W] == DIV_OUT_W'(1)))
    else $error("error beat with unexpected fields");

  // The filter width is never below the narrowest table entry.
  a_filt_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      (out_tdata_r[SYNTH_W+DIV_OUT_W+FILT_W-1:SYNTH_W+DIV_OUT_W] >= FILTER_TABLE[0]))
    else $error("filter width below table");

endmodule

FILE: src/srds_ctrl.sv
module srds_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  srds_pkg::srds_status_t status,
  output logic                   in_tready,
  output srds_pkg::srds_cmd_t    cmd
);
  import srds_pkg::*;

  srds_state_t state_r;
  srds_state_t state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = status.in_err ? ST_FINISH : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status.hit || status.last) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_nxt = ST_TRIPLE;
      end
      ST_TRIPLE: begin
        state_nxt = ST_FILTER;
      end
      ST_FILTER: begin
        if (status.filt_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath; no beat is taken while reset is held.
  always_comb begin
    cmd       = CMD_NONE;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd = CMD_LOAD;
        end
      end
      ST_SEARCH: begin
        if (status.hit) begin
          cmd = CMD_NONE;
        end else if (status.last) begin
          cmd = CMD_FALLBACK;
        end else begin
          cmd = CMD_STEP;
        end
      end
      ST_ROUND: begin
        cmd = CMD_ROUND;
      end
      ST_TRIPLE: begin
        cmd = CMD_TRIPLE;
      end
      ST_FILTER: begin
        cmd = CMD_FILT;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd = CMD_FINISH;
        end
      end
      default: begin
        cmd = CMD_NONE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A qualifying multiple ends the search at once.
  a_hit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH && status.hit) |=> state_r == ST_ROUND)
    else $error("search continued past a qualifying multiple");

endmodule

FILE: src/sample_rate_divider_search_core.sv
// Operation: each input beat is searched over at most MAX_TRIES-1 multiples, then
// rounded, tripled and scanned against the filter table; out-of-range input skips these.
// Input: a new beat is taken only in idle, once the last result is loaded; the serial
// search adder and the sixteen-step filter table scan bound how often beats are taken.
// Reset: synchronous, active low; clears the controller state and output valid.
module sample_rate_divider_search_core #(
  parameter int MAX_TRIES = srds_pkg::MAX_TRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [srds_pkg::IN_TDATA_W-1:0]  in_tdata,   // [63:0] rate_bits
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [32:0] synth_freq_hz, [37:33] rate_divider, [62:38] filter_width_hz, [63] zero
  output logic [srds_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tuser   // [0] range_error
);
  import srds_pkg::*;

  srds_cmd_t    cmd;
  srds_status_t status;

  // Sequencer.
  srds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .status    (status),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  // Search, rounding and filter datapath with the output register.
  srds_datapath #(
    .MAX_TRIES (MAX_TRIES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .rate_bits  (in_tdata),
    .cmd        (cmd),
    .out_tready (out_tready),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
